FILE: hdl/arr_pkg.sv
// shared types, constants and helpers of the audio rate resampler
package arr_pkg;

    // field and state widths
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 19;
    localparam int MAXO_W   = 22;
    localparam int CNT_W    = 21;
    localparam int PHASE_W  = 37;
    localparam int STEP_W   = 35;
    localparam int PROD_W   = 41;
    localparam int FRAC_W   = 15;

    // history ring and burst limits
    localparam int HIST_DEPTH  = 64;
    localparam int HIST_AW     = 6;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;
    localparam int MAX_PACKET_SAMPLES = 1048576;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 22;

    // step divider
    localparam int DIV_STEPS = 35;
    localparam int DIV_CNT_W = 6;

    // register defaults
    localparam logic [RATE_W-1:0] IN_RATE_DFLT  = 19'd44100;
    localparam logic [RATE_W-1:0] OUT_RATE_DFLT = 19'd128000;
    localparam logic [MAXO_W-1:0] MAX_OUT_DFLT  = 22'd2097152;
    localparam logic [STEP_W-1:0] STEP_RESET    =
        STEP_W'((64'd44100 << 16) / 64'd128000);

    // register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_IN_RATE     = 2'd0,
        REG_OUT_RATE    = 2'd1,
        REG_MODE        = 2'd2,
        REG_MAX_OUTPUTS = 2'd3
    } cfg_reg_t;

    // interpolation modes
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_LINEAR  = 1'b1;

    // settled configuration seen by the back end
    typedef struct packed {
        logic [RATE_W-1:0] in_rate;
        logic [RATE_W-1:0] out_rate;
        logic              mode;
        logic [MAXO_W-1:0] max_outputs;
        logic [STEP_W-1:0] step;
        logic              rates_equal;
        logic              busy;
    } cfg_t;

    // one classified input word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [CNT_W-1:0]    n;
    } qitem_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        B_IDLE,
        B_WRITE,
        B_MUL,
        B_PK,
        B_CHECK,
        B_RDA,
        B_RDB,
        B_INT,
        B_PASS,
        B_DONE
    } back_state_t;

    // ring address of packet sample idx with newest sample n, clamped to what is held
    function automatic logic [HIST_AW-1:0] hist_addr(input logic [CNT_W:0] idx,
                                                     input logic [CNT_W-1:0] n);
        logic [CNT_W:0] nx;
        logic [CNT_W:0] sel;
        logic [CNT_W:0] gap;
        nx  = {1'b0, n};
        sel = (idx > nx) ? nx : idx;
        gap = nx - sel;
        if (gap >= (CNT_W+1)'(HIST_DEPTH)) begin
            sel = nx - (CNT_W+1)'(HIST_DEPTH - 1);
        end
        return sel[HIST_AW-1:0];
    endfunction

endpackage

FILE: hdl/audio_rate_resampler_core.sv
// Top level of the audio rate resampler (nearest or linear, Q16 phase).
// The back end works through one queued input word and all of its output words before
// it pops the next; the front-end queue keeps taking input words meanwhile while it has room.
// The word rate, in both modes, is set by the back-end sequencer and the one ram read port;
// at equal rates by the sequencer alone.
// Rate write: the serial step divide holds input off. Reset (aresetn low, sync): defaults.
module audio_rate_resampler_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [arr_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [arr_pkg::CFG_DW-1:0]    cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [arr_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                          s_tlast,   // last_sample
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [arr_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] out_sample
    output logic                          m_tlast    // out_last
);

    arr_pkg::cfg_t   cfg;
    logic            q_valid;
    arr_pkg::qitem_t q_item;
    logic            q_pop;

    // registers and step divider
    arr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // front end and queue
    arr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_busy (cfg.busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back end
    arr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hdl/arr_ram.sv
// generic single write, single read ram with registered read data
module arr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/arr_cfg.sv
// configuration registers and the bit-serial phase step divider
module arr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [arr_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [arr_pkg::CFG_DW-1:0]  cfg_wr_data,
    output arr_pkg::cfg_t               cfg
);

    logic [arr_pkg::RATE_W-1:0]    in_rate_reg, in_rate_next;
    logic [arr_pkg::RATE_W-1:0]    out_rate_reg, out_rate_next;
    logic                          mode_reg, mode_next;
    logic [arr_pkg::MAXO_W-1:0]    max_reg, max_next;
    logic [arr_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic [arr_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [arr_pkg::STEP_W-1:0]    num_reg, num_next;
    logic [arr_pkg::RATE_W-1:0]    rem_reg, rem_next;
    logic [arr_pkg::STEP_W-1:0]    quo_reg, quo_next;

    logic [arr_pkg::RATE_W-1:0] eff_in;
    logic [arr_pkg::RATE_W-1:0] eff_out;
    logic [arr_pkg::RATE_W:0]   rem_shift;
    logic                       q_bit;

    // zero stands for the default rate
    assign eff_in  = (in_rate_reg  == '0) ? arr_pkg::IN_RATE_DFLT  : in_rate_reg;
    assign eff_out = (out_rate_reg == '0) ? arr_pkg::OUT_RATE_DFLT : out_rate_reg;

    // one restoring divide step
    assign rem_shift = {rem_reg, num_reg[arr_pkg::STEP_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, eff_out});

    // register writes and divider sequencing
    always_comb begin
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        mode_next     = mode_reg;
        max_next      = max_reg;
        step_next     = step_reg;
        busy_next     = busy_reg;
        div_cnt_next  = div_cnt_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;

        if (div_cnt_reg == arr_pkg::DIV_CNT_W'(arr_pkg::DIV_STEPS + 1)) begin
            // load dividend in << 16
            num_next     = {eff_in, 16'd0};
            rem_next     = '0;
            quo_next     = '0;
            div_cnt_next = arr_pkg::DIV_CNT_W'(arr_pkg::DIV_STEPS);
        end else if (div_cnt_reg != '0) begin
            num_next     = {num_reg[arr_pkg::STEP_W-2:0], 1'b0};
            rem_next     = q_bit ? arr_pkg::RATE_W'(rem_shift - {1'b0, eff_out})
                                 : rem_shift[arr_pkg::RATE_W-1:0];
            quo_next     = {quo_reg[arr_pkg::STEP_W-2:0], q_bit};
            div_cnt_next = div_cnt_reg - 1'b1;
            if (div_cnt_reg == arr_pkg::DIV_CNT_W'(1)) begin
                step_next = {quo_reg[arr_pkg::STEP_W-2:0], q_bit};
                busy_next = 1'b0;
            end
        end

        if (cfg_wr_en) begin
            case (arr_pkg::cfg_reg_t'(cfg_addr))
                arr_pkg::REG_IN_RATE: begin
                    in_rate_next = cfg_wr_data[arr_pkg::RATE_W-1:0];
                    busy_next    = 1'b1;
                    div_cnt_next = arr_pkg::DIV_CNT_W'(arr_pkg::DIV_STEPS + 1);
                end
                arr_pkg::REG_OUT_RATE: begin
                    out_rate_next = cfg_wr_data[arr_pkg::RATE_W-1:0];
                    busy_next     = 1'b1;
                    div_cnt_next  = arr_pkg::DIV_CNT_W'(arr_pkg::DIV_STEPS + 1);
                end
                arr_pkg::REG_MODE: begin
                    mode_next = cfg_wr_data[0];
                end
                arr_pkg::REG_MAX_OUTPUTS: begin
                    max_next = cfg_wr_data[arr_pkg::MAXO_W-1:0];
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= arr_pkg::IN_RATE_DFLT;
            out_rate_reg <= arr_pkg::OUT_RATE_DFLT;
            mode_reg     <= arr_pkg::MODE_NEAREST;
            max_reg      <= arr_pkg::MAX_OUT_DFLT;
            step_reg     <= arr_pkg::STEP_RESET;
            busy_reg     <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
            mode_reg     <= mode_next;
            max_reg      <= max_next;
            step_reg     <= step_next;
            busy_reg     <= busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign cfg.in_rate     = eff_in;
    assign cfg.out_rate    = eff_out;
    assign cfg.mode        = mode_reg;
    assign cfg.max_outputs = max_reg;
    assign cfg.step        = step_reg;
    assign cfg.rates_equal = (eff_in == eff_out);
    assign cfg.busy        = busy_reg;

endmodule

FILE: hdl/arr_front.sv
// input side: packet sample count, end-of-packet marking and the work queue
module arr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_busy,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [arr_pkg::SAMPLE_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          q_valid,
    output arr_pkg::qitem_t               q_item,
    input  logic                          q_pop
);

    logic [arr_pkg::CNT_W-1:0]  in_count_reg, in_count_next;
    arr_pkg::qitem_t            q_mem_reg [arr_pkg::QUEUE_DEPTH];
    logic [arr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [arr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [arr_pkg::QCNT_W-1:0] count_reg, count_next;

    logic                       push;
    logic [arr_pkg::CNT_W:0]    c;
    logic                       last_f;
    arr_pkg::qitem_t            item;

    assign s_tready = (count_reg < arr_pkg::QCNT_W'(arr_pkg::QUEUE_DEPTH)) && !cfg_busy;
    assign push     = s_tvalid && s_tready;

    // classify the word: its index and whether it closes the packet
    assign c      = {1'b0, in_count_reg} + 1'b1;
    assign last_f = s_tlast || (32'(c) >= 32'(arr_pkg::MAX_PACKET_SAMPLES));

    always_comb begin
        item.sample = s_tdata;
        item.last   = last_f;
        item.n      = in_count_reg;
    end

    // pointers and counts
    always_comb begin
        in_count_next = in_count_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        if (push) begin
            in_count_next = last_f ? '0 : c[arr_pkg::CNT_W-1:0];
            wr_ptr_next   = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            in_count_reg <= in_count_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

endmodule

FILE: hdl/arr_back.sv
// output side: per-word sequencer; words from the history ring, or the input word at equal rates
module arr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arr_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  arr_pkg::qitem_t               q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [arr_pkg::SAMPLE_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    arr_pkg::back_state_t state_reg, state_next;

    logic [arr_pkg::SAMPLE_W-1:0] smp_reg, smp_next;
    logic                         last_reg, last_next;
    logic [arr_pkg::CNT_W-1:0]    n_reg, n_next;
    logic                         lin_reg, lin_next;
    logic [arr_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [arr_pkg::MAXO_W-1:0]   oc_reg, oc_next;
    logic [arr_pkg::RES_W-1:0]    cnt_reg, cnt_next;
    logic [arr_pkg::PROD_W-1:0]   mul_reg, mul_next;
    logic [arr_pkg::PROD_W-1:0]   co_reg, co_next;
    logic [arr_pkg::PROD_W-1:0]   pk_reg, pk_next;
    logic signed [arr_pkg::SAMPLE_W-1:0] a_reg, a_next;
    logic signed [32:0]           ip_reg, ip_next;
    logic                         mv_reg, mv_next;
    logic [arr_pkg::SAMPLE_W-1:0] md_reg, md_next;
    logic                         ml_reg, ml_next;

    logic [arr_pkg::MAXO_W-1:0]   mul_a;
    logic [arr_pkg::RATE_W-1:0]   mul_b;
    logic [arr_pkg::CNT_W:0]      c;
    logic [arr_pkg::CNT_W:0]      idx_x;
    logic [arr_pkg::CNT_W:0]      idx1;
    logic [arr_pkg::MAXO_W:0]     oc1;
    logic [arr_pkg::MAXO_W:0]     max_x;
    logic [arr_pkg::PROD_W:0]     pk_i;
    logic                         slot_free;
    logic                         may_emit;
    logic                         more;
    logic signed [16:0]           diff;
    logic signed [33:0]           y_full;

    logic                         ram_wr_en;
    logic [arr_pkg::HIST_AW-1:0]  ram_rd_addr;
    logic [arr_pkg::SAMPLE_W-1:0] ram_rd_data;

    // packet sample history
    arr_ram #(
        .WIDTH (arr_pkg::SAMPLE_W),
        .DEPTH (arr_pkg::HIST_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (n_reg[arr_pkg::HIST_AW-1:0]),
        .wr_data (smp_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // per-output derived values
    assign c         = {1'b0, n_reg} + 1'b1;
    assign idx_x     = {1'b0, phase_reg[arr_pkg::PHASE_W-1:16]};
    assign idx1      = idx_x + 1'b1;
    assign oc1       = {1'b0, oc_reg} + 1'b1;
    assign max_x     = {1'b0, cfg.max_outputs};
    assign pk_i      = {1'b0, pk_reg} + (arr_pkg::PROD_W+1)'(cfg.in_rate);
    assign slot_free = !mv_reg || m_tready;
    assign more      = (pk_i < {1'b0, co_reg}) && (oc1 < max_x);

    // output count within the per-word burst limit, the known length and the cap, samples present
    assign may_emit = (cnt_reg < arr_pkg::RES_W'(arr_pkg::MAX_RESULTS))
                   && (oc_reg < cfg.max_outputs)
                   && (pk_reg < co_reg)
                   && (last_reg || (idx_x < {1'b0, n_reg}));

    // interpolation arithmetic
    assign diff   = $signed({ram_rd_data[arr_pkg::SAMPLE_W-1], ram_rd_data})
                  - $signed({a_reg[arr_pkg::SAMPLE_W-1], a_reg});
    assign y_full = 34'(a_reg) + 34'(ip_reg >>> arr_pkg::FRAC_W);

    // shared rate multiplier
    assign mul_next = arr_pkg::PROD_W'(mul_a) * arr_pkg::PROD_W'(mul_b);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        smp_next    = smp_reg;
        last_next   = last_reg;
        n_next      = n_reg;
        lin_next    = lin_reg;
        phase_next  = phase_reg;
        oc_next     = oc_reg;
        cnt_next    = cnt_reg;
        co_next     = co_reg;
        pk_next     = pk_reg;
        a_next      = a_reg;
        ip_next     = ip_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        ml_next     = ml_reg;
        mul_a       = '0;
        mul_b       = '0;
        q_pop       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_addr = arr_pkg::hist_addr(idx_x, n_reg);

        case (state_reg)
            arr_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    smp_next   = q_item.sample;
                    last_next  = q_item.last;
                    n_next     = q_item.n;
                    cnt_next   = '0;
                    state_next = arr_pkg::B_WRITE;
                end
            end
            arr_pkg::B_WRITE: begin
                // store sample, start received*out product
                ram_wr_en = 1'b1;
                mul_a     = c;
                mul_b     = cfg.out_rate;
                state_next = cfg.rates_equal ? arr_pkg::B_PASS : arr_pkg::B_MUL;
            end
            arr_pkg::B_MUL: begin
                co_next    = mul_reg;
                mul_a      = oc_reg;
                mul_b      = cfg.in_rate;
                state_next = arr_pkg::B_PK;
            end
            arr_pkg::B_PK: begin
                pk_next    = mul_reg;
                state_next = arr_pkg::B_CHECK;
            end
            arr_pkg::B_CHECK: begin
                // read address of the lower sample goes out here
                lin_next   = (cfg.mode == arr_pkg::MODE_LINEAR) && (idx1 < c);
                state_next = may_emit ? arr_pkg::B_RDA : arr_pkg::B_DONE;
            end
            arr_pkg::B_RDA: begin
                a_next      = ram_rd_data;
                ram_rd_addr = arr_pkg::hist_addr(idx1, n_reg);
                if (lin_reg) begin
                    state_next = arr_pkg::B_RDB;
                end else begin
                    ip_next    = '0;
                    state_next = arr_pkg::B_INT;
                end
            end
            arr_pkg::B_RDB: begin
                ip_next    = diff * $signed({1'b0, phase_reg[15:1]});
                state_next = arr_pkg::B_INT;
            end
            arr_pkg::B_INT: begin
                if (slot_free) begin
                    mv_next    = 1'b1;
                    md_next    = y_full[arr_pkg::SAMPLE_W-1:0];
                    ml_next    = (oc1 == max_x) || (last_reg && !more);
                    phase_next = phase_reg + arr_pkg::PHASE_W'(cfg.step);
                    oc_next    = oc1[arr_pkg::MAXO_W-1:0];
                    pk_next    = pk_i[arr_pkg::PROD_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = arr_pkg::B_CHECK;
                end
            end
            arr_pkg::B_PASS: begin
                // equal rates: sample goes straight out
                if (oc_reg >= cfg.max_outputs) begin
                    state_next = arr_pkg::B_DONE;
                end else if (slot_free) begin
                    mv_next    = 1'b1;
                    md_next    = smp_reg;
                    ml_next    = last_reg || (oc1 == max_x);
                    oc_next    = oc1[arr_pkg::MAXO_W-1:0];
                    state_next = arr_pkg::B_DONE;
                end
            end
            arr_pkg::B_DONE: begin
                if (last_reg) begin
                    phase_next = '0;
                    oc_next    = '0;
                end
                state_next = arr_pkg::B_IDLE;
            end
            default: begin
                state_next = arr_pkg::B_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arr_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            oc_reg    <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            oc_reg    <= oc_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        smp_reg  <= smp_next;
        last_reg <= last_next;
        n_reg    <= n_next;
        lin_reg  <= lin_next;
        mul_reg  <= mul_next;
        co_reg   <= co_next;
        pk_reg   <= pk_next;
        a_reg    <= a_next;
        ip_reg   <= ip_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule
